/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file fcv_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define FCV_ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FCV_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/fcv_pkg.sv */
// ----------------------------------------------------------------------------
// fcv_pkg
// Shared constants and types of the valid-mode FIR convolution block.
// ----------------------------------------------------------------------------
package fcv_pkg;

    // Filter geometry
    localparam int MAX_TAPS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int TAP_AW      = $clog2(MAX_TAPS);
    localparam int KW          = $clog2(MAX_TAPS + 1);

    // Word field widths
    localparam int VALUE_W   = 16;
    localparam int TAP_IDX_W = 4;
    localparam int CFG_W     = 5;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 16;

    // Tap count after reset
    localparam logic [CFG_W-1:0] TAP_COUNT_RST = CFG_W'(16);

    // Command queue depth between front and back end
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Item kinds on the input tuser
    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // One classified command for the back end
    typedef struct packed {
        logic                 is_sample;
        logic [TAP_AW-1:0]    tap_idx;
        logic [VALUE_W-1:0]   value;
        logic                 last;
        logic                 emit;
        logic [KW-1:0]        k;
    } t_cmd;

endpackage

/* hw/rtl/fir_convolution_valid_mode.sv */
// ----------------------------------------------------------------------------
// fir_convolution_valid_mode
// Streaming direct-form FIR filter with valid-mode convolution output.
// ----------------------------------------------------------------------------
// Words with tuser 0 load one signed coefficient into slot tdata[3:0]; words
// with tuser 1 shift one Q1.15 sample (tdata[19:4]) into the delay line, and
// once the current block holds tap_count samples each one gives the sum of
// coef[j] * x[n-j], rounded half up, shifted right by 15 and saturated, with
// tuser set on clipping. A tap count of zero acts as one tap and one above
// 16 as 16. tlast on a sample closes the block. A coefficient load or a
// sample that gives no output is handled in the idle state alone; a
// sample that gives an output then runs the multiply, accumulate and output
// states, since one shared multiplier walks the taps one per cycle, and
// stays in S_OUT while the previous word waits for the sink. A four-word
// command queue lets the input side keep accepting while the execution side
// works. The output word is registered, so the next result is computed while
// the sink stalls; once that result is also ready the execution side waits
// and, when the queue is full, input stalls. Write tap_count only while the
// block is idle.
// ----------------------------------------------------------------------------
module fir_convolution_valid_mode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration: tap_count
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fcv_pkg::CFG_W-1:0]      i_cfg_data,
    // Input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [fcv_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // [3:0] tap_index, [19:4] value
    input  logic                           i_s_axis_tuser,  // [0] kind
    input  logic                           i_s_axis_tlast,  // block_end
    // Output stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [fcv_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // [15:0] result
    output logic                           o_m_axis_tuser,  // [0] saturated
    output logic                           o_m_axis_tlast   // block_last
);
    import fcv_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    fcv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser),
        .i_tap_index (i_s_axis_tdata[TAP_IDX_W-1:0]),
        .i_value     (i_s_axis_tdata[TAP_IDX_W +: VALUE_W]),
        .i_block_end (i_s_axis_tlast),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (full)
    );

    fcv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (head_cmd),
        .o_empty (empty)
    );

    fcv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (head_cmd),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_result     (o_m_axis_tdata),
        .o_saturated  (o_m_axis_tuser),
        .o_block_last (o_m_axis_tlast)
    );

endmodule

/* hw/rtl/fcv_queue.sv */
// ----------------------------------------------------------------------------
// fcv_queue
// Small FIFO of classified commands between the front and back end.
// ----------------------------------------------------------------------------
module fcv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcv_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output fcv_pkg::t_cmd o_rdata,
    output logic          o_empty
);
    import fcv_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW:0]   r_wptr;
    logic [QAW:0]   r_rptr;

    assign o_empty = (r_wptr == r_rptr);
    assign o_full  = (r_wptr[QAW-1:0] == r_rptr[QAW-1:0]) && (r_wptr[QAW] != r_rptr[QAW]);
    assign o_rdata = r_mem[r_rptr[QAW-1:0]];

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr[QAW-1:0]] <= i_wdata;
        end
    end

endmodule

/* hw/rtl/fcv_front.sv */
// ----------------------------------------------------------------------------
// fcv_front
// Input side: holds the tap count, tracks the block fill and turns each
// accepted word into a command for the back end.
// ----------------------------------------------------------------------------
module fcv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fcv_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [fcv_pkg::TAP_IDX_W-1:0] i_tap_index,
    input  logic [fcv_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_block_end,
    output logic                          o_push,
    output fcv_pkg::t_cmd                 o_cmd,
    input  logic                          i_full
);
    import fcv_pkg::*;

    logic [CFG_W-1:0] r_tap_count;
    logic [KW-1:0]    r_fill;
    logic [KW-1:0]    k_eff;
    logic [KW:0]      fill_p1;
    logic [KW-1:0]    fill_new;
    logic             accept;
    logic             coef_ok;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_full;
    assign accept      = i_in_valid && !i_full;

    // Clamp the tap count into one to MAX_TAPS
    always_comb begin
        if (r_tap_count == '0) begin
            k_eff = KW'(1);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            k_eff = KW'(MAX_TAPS);
        end else begin
            k_eff = KW'(r_tap_count);
        end
    end

    // Count the sample into the block, never beyond the tap count
    assign fill_p1  = {1'b0, r_fill} + 1'b1;
    assign fill_new = (fill_p1 > {1'b0, k_eff}) ? k_eff : fill_p1[KW-1:0];

    // Drop coefficient loads aimed past the last slot
    assign coef_ok = (32'(i_tap_index) < MAX_TAPS);

    // Build the command
    always_comb begin
        o_cmd.is_sample = (i_kind == KIND_SAMPLE);
        o_cmd.tap_idx   = TAP_AW'(i_tap_index);
        o_cmd.value     = i_value;
        o_cmd.last      = i_block_end;
        o_cmd.emit      = (fill_new == k_eff);
        o_cmd.k         = k_eff;
    end
    assign o_push = accept && ((i_kind == KIND_SAMPLE) || coef_ok);

    // Hold tap count and block fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
            r_fill      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_tap_count <= i_cfg_data;
            end
            if (accept && (i_kind == KIND_SAMPLE)) begin
                r_fill <= i_block_end ? '0 : fill_new;
            end
        end
    end

endmodule

/* hw/rtl/fcv_back.sv */
// ----------------------------------------------------------------------------
// fcv_back
// Execution side: coefficient store, delay line and one shared
// multiply-accumulate unit that walks the taps, then rounds and saturates.
// ----------------------------------------------------------------------------
module fcv_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fcv_pkg::t_cmd                  i_cmd,
    input  logic                           i_empty,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [fcv_pkg::OUT_DATA_W-1:0] o_result,
    output logic                           o_saturated,
    output logic                           o_block_last
);
    import fcv_pkg::*;

    localparam int PROD_W = 2 * VALUE_W;
    localparam int ACC_W  = PROD_W + TAP_AW;
    localparam int SH     = SAMPLE_BITS - 1;
    localparam logic signed [ACC_W-1:0] ACC_OUT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ACC_OUT_MIN = ACC_W'(-32768);
    localparam logic signed [ACC_W-1:0] ACC_HALF    = ACC_W'(1) <<< (SH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    t_state                     r_state;
    logic signed [VALUE_W-1:0]  r_coef  [MAX_TAPS];
    logic signed [VALUE_W-1:0]  r_delay [MAX_TAPS];
    logic [TAP_AW-1:0]          r_j;
    logic [TAP_AW-1:0]          r_jlast;
    logic                       r_last;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_pv;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_valid;
    logic [OUT_DATA_W-1:0]      r_result;
    logic                       r_saturated;
    logic                       r_block_last;

    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [ACC_W-1:0]    y;
    logic [KW-1:0]              k_m1;

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid  = r_out_valid;
    assign o_result     = r_result;
    assign o_saturated  = r_saturated;
    assign o_block_last = r_block_last;

    assign prod = r_coef[r_j] * r_delay[r_j];
    assign rnd  = r_acc + ACC_HALF;
    assign y    = rnd >>> SH;
    assign k_m1 = i_cmd.k - 1'b1;

    // Store coefficients and shift samples in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_coef[i]  <= '0;
                r_delay[i] <= '0;
            end
        end else if (o_pop) begin
            if (i_cmd.is_sample) begin
                for (int i = MAX_TAPS - 1; i > 0; i--) begin
                    r_delay[i] <= r_delay[i-1];
                end
                r_delay[0] <= $signed(i_cmd.value);
            end else begin
                r_coef[i_cmd.tap_idx] <= $signed(i_cmd.value);
            end
        end
    end

    // Sequence the taps and hold the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            // Drop the taken output word; the output state reloads it itself
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_cmd.is_sample && i_cmd.emit) begin
                        r_j     <= '0;
                        r_jlast <= TAP_AW'(k_m1);
                        r_last  <= i_cmd.last;
                        r_acc   <= '0;
                        r_pv    <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= prod;
                    r_pv   <= 1'b1;
                    if (r_pv) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    if (r_j == r_jlast) begin
                        r_state <= S_ACC;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_ACC: begin
                    r_acc   <= r_acc + ACC_W'(r_prod);
                    r_pv    <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Load the output word once the previous one is taken
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_block_last <= r_last;
                        if (y > ACC_OUT_MAX) begin
                            r_result    <= OUT_DATA_W'(ACC_OUT_MAX);
                            r_saturated <= 1'b1;
                        end else if (y < ACC_OUT_MIN) begin
                            r_result    <= OUT_DATA_W'(ACC_OUT_MIN);
                            r_saturated <= 1'b1;
                        end else begin
                            r_result    <= OUT_DATA_W'(y);
                            r_saturated <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/fcv_checker.sv */
// ----------------------------------------------------------------------------
// fcv_checker
// Port-level checks of the FIR convolution block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcv_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [fcv_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                           o_m_axis_tuser
);
    import fcv_pkg::*;

    // A word offered and not taken stays offered
    `FCV_ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "output word dropped while stalled")

    // A clipped word sits at one of the range limits
    `FCV_ASSERT_CLK_RST(a_sat_limit, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == 16'h7fff || o_m_axis_tdata == 16'h8000, "saturation flag on an in-range word")

    // Reset empties the output register
    `FCV_ASSERT_CLK(a_rst_clear, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind fir_convolution_valid_mode fcv_checker u_fcv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
